>>> src/plsu_pkg.sv
package plsu_pkg;

    // Default list depth
    localparam int unsigned CAPACITY_DEF = 16;

    // Request codes carried in the input tuser
    typedef enum logic [3:0] {
        REQ_PUSH_FRONT = 4'd0,
        REQ_PUSH_BACK  = 4'd1,
        REQ_POP_FRONT  = 4'd2,
        REQ_POP_BACK   = 4'd3,
        REQ_PEEK_FRONT = 4'd4,
        REQ_PEEK_BACK  = 4'd5,
        REQ_INSERT     = 4'd6,
        REQ_REMOVE     = 4'd7,
        REQ_WRITE      = 4'd8,
        REQ_READ       = 4'd9,
        REQ_FIND       = 4'd10
    } t_req;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Float -1.0, returned on every error
    localparam logic [31:0] ERR_VALUE = 32'hBF80_0000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_INS,
        S_REM,
        S_FIND,
        S_FINISH
    } t_state;

endpackage

>>> src/positional_list_store_unit.sv
// Channel   Dir  Handshake             Payload
// s (req)   in   i_s_tvalid/o_s_tready tuser: req_type; tdata: slot, item_value
// m (rsp)   out  o_m_tvalid/i_m_tready tuser: status; tdata: value, slot, found, length
//
// End pushes, pops, peeks, write and read make at most one entry RAM access each.
// Interior insert and interior remove move one entry per cycle, and find scans one
// entry per cycle up to the match; the one-entry-per-cycle rate is set by the single
// read and write port of the entry RAM.
// Reset clears the control state only; the entry RAM holds no reset value.
// A finished result waits in the output register; the next request is taken
// meanwhile and completes once that register is free.
module positional_list_store_unit #(
    parameter int unsigned CAPACITY = plsu_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // slot[4:0], item_value[36:5], zero pad
    input  logic [3:0]  i_s_tuser,   // req_type[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // read_value[31:0], found_slot[36:32],
                                     // found[37], length[42:38], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

    localparam logic [CW-1:0]   ONE_C  = CW'(1);
    localparam logic [CW-1:0]   CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0]   CAP_M1 = AW'(CAPACITY - 1);
    localparam logic [AW+1:0]   CAP_S  = (AW + 2)'(CAPACITY);
    localparam logic [CMPW-1:0] ONE_X  = CMPW'(1);

    // Map a logical position onto the circular buffer
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
        logic [AW+1:0] s;
        s = (AW + 2)'(h) + (AW + 2)'(l);
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic is_nan(input logic [31:0] v);
        return (&v[30:23]) && (|v[22:0]);
    endfunction

    // IEEE single equality: signed zeros match, NaN never does
    function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && ((((a | b) & 32'h7FFF_FFFF) == 32'h0) || (a == b));
    endfunction

    plsu_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pidx, n_pidx;
    logic          r_rd_on, n_rd_on;
    logic          r_pv, n_pv;

    logic [3:0]    r_req;
    logic [4:0]    r_slot;
    logic [31:0]   r_val;

    logic [1:0]    r_status, n_status;
    logic [31:0]   r_rv, n_rv;
    logic [CW-1:0] r_fslot, n_fslot;
    logic          r_found, n_found;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_value;
    logic [4:0]    r_o_fslot;
    logic          r_o_found;
    logic [4:0]    r_o_length;
    logic          c_load;

    logic                c_we, c_re;
    logic [AW-1:0]       c_waddr, c_raddr;
    logic [31:0]         c_wdata, c_rdata;

    logic                c_accept;
    logic [CMPW-1:0]     c_slot_x, c_n_x, c_km1;
    logic [CW-1:0]       c_k;
    logic                c_ins_ok, c_pos_ok, c_full, c_empty, c_match;
    logic [AW-1:0]       c_hinc, c_hdec;
    logic [CW+4:0]       c_len_x, c_fs_x;

    // Decode helpers
    assign c_accept = i_s_tvalid && o_s_tready;
    assign c_slot_x = CMPW'(r_slot);
    assign c_n_x    = CMPW'(r_count);
    assign c_km1    = c_slot_x - ONE_X;
    assign c_k      = c_km1[CW-1:0];
    assign c_ins_ok = (c_slot_x != '0) && (c_slot_x <= c_n_x + ONE_X);
    assign c_pos_ok = (c_slot_x != '0) && (c_slot_x <= c_n_x);
    assign c_full   = (r_count == CAP_C);
    assign c_empty  = (r_count == '0);
    assign c_match  = r_pv && ieee_eq(c_rdata, r_val);
    assign c_hinc   = (r_head == CAP_M1) ? '0 : r_head + AW'(1);
    assign c_hdec   = (r_head == '0) ? CAP_M1 : r_head - AW'(1);
    assign c_len_x  = (CW + 5)'(r_count);
    assign c_fs_x   = (CW + 5)'(r_fslot);
    assign c_load   = (r_state == plsu_pkg::S_FINISH) && (!r_out_valid || i_m_tready);

    plsu_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plsu_pkg::S_IDLE: begin
                if (c_accept) begin
                    n_state = plsu_pkg::S_EXEC;
                end
            end
            plsu_pkg::S_EXEC: begin
                unique case (r_req)
                    plsu_pkg::REQ_POP_FRONT, plsu_pkg::REQ_POP_BACK,
                    plsu_pkg::REQ_PEEK_FRONT, plsu_pkg::REQ_PEEK_BACK: begin
                        n_state = c_empty ? plsu_pkg::S_FINISH : plsu_pkg::S_RDWAIT;
                    end
                    plsu_pkg::REQ_INSERT: begin
                        if (!c_ins_ok || c_full || c_k == '0 || c_k == r_count) begin
                            n_state = plsu_pkg::S_FINISH;
                        end else begin
                            n_state = plsu_pkg::S_INS;
                        end
                    end
                    plsu_pkg::REQ_REMOVE: begin
                        if (!c_pos_ok) begin
                            n_state = plsu_pkg::S_FINISH;
                        end else if (c_k == '0 || c_k == r_count - ONE_C) begin
                            n_state = plsu_pkg::S_RDWAIT;
                        end else begin
                            n_state = plsu_pkg::S_REM;
                        end
                    end
                    plsu_pkg::REQ_READ: begin
                        n_state = c_pos_ok ? plsu_pkg::S_RDWAIT : plsu_pkg::S_FINISH;
                    end
                    plsu_pkg::REQ_FIND: begin
                        n_state = c_empty ? plsu_pkg::S_FINISH : plsu_pkg::S_FIND;
                    end
                    default: begin
                        n_state = plsu_pkg::S_FINISH;
                    end
                endcase
            end
            plsu_pkg::S_RDWAIT: begin
                n_state = plsu_pkg::S_FINISH;
            end
            plsu_pkg::S_INS, plsu_pkg::S_REM: begin
                if (!r_rd_on && !r_pv) begin
                    n_state = plsu_pkg::S_FINISH;
                end
            end
            plsu_pkg::S_FIND: begin
                if (c_match || (!r_rd_on && !r_pv)) begin
                    n_state = plsu_pkg::S_FINISH;
                end
            end
            plsu_pkg::S_FINISH: begin
                if (c_load) begin
                    n_state = plsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plsu_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result values
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_pidx   = r_pidx;
        n_rd_on  = r_rd_on;
        n_pv     = 1'b0;
        n_status = r_status;
        n_rv     = r_rv;
        n_fslot  = r_fslot;
        n_found  = r_found;
        c_we     = 1'b0;
        c_waddr  = '0;
        c_wdata  = r_val;
        c_re     = 1'b0;
        c_raddr  = '0;

        unique case (r_state)
            plsu_pkg::S_IDLE: begin
                n_status = plsu_pkg::ST_OK;
                n_rv     = '0;
                n_fslot  = '0;
                n_found  = 1'b0;
                n_rd_on  = 1'b0;
            end
            plsu_pkg::S_EXEC: begin
                unique case (r_req)
                    plsu_pkg::REQ_PUSH_FRONT, plsu_pkg::REQ_PUSH_BACK: begin
                        if (c_full) begin
                            n_status = plsu_pkg::ST_FULL;
                        end else begin
                            c_we    = 1'b1;
                            n_count = r_count + ONE_C;
                            if (r_req == plsu_pkg::REQ_PUSH_FRONT) begin
                                n_head  = c_hdec;
                                c_waddr = c_hdec;
                            end else begin
                                c_waddr = phys(r_head, r_count);
                            end
                        end
                    end
                    plsu_pkg::REQ_POP_FRONT, plsu_pkg::REQ_POP_BACK,
                    plsu_pkg::REQ_PEEK_FRONT, plsu_pkg::REQ_PEEK_BACK: begin
                        if (c_empty) begin
                            n_status = plsu_pkg::ST_EMPTY;
                        end else begin
                            c_re = 1'b1;
                            if (r_req == plsu_pkg::REQ_POP_FRONT ||
                                r_req == plsu_pkg::REQ_PEEK_FRONT) begin
                                c_raddr = r_head;
                            end else begin
                                c_raddr = phys(r_head, r_count - ONE_C);
                            end
                            if (r_req == plsu_pkg::REQ_POP_FRONT) begin
                                n_head  = c_hinc;
                                n_count = r_count - ONE_C;
                            end else if (r_req == plsu_pkg::REQ_POP_BACK) begin
                                n_count = r_count - ONE_C;
                            end
                        end
                    end
                    plsu_pkg::REQ_INSERT: begin
                        if (!c_ins_ok) begin
                            n_status = plsu_pkg::ST_BADPOS;
                        end else if (c_full) begin
                            n_status = plsu_pkg::ST_FULL;
                        end else if (c_k == '0) begin
                            c_we    = 1'b1;
                            n_head  = c_hdec;
                            c_waddr = c_hdec;
                            n_count = r_count + ONE_C;
                        end else if (c_k == r_count) begin
                            c_we    = 1'b1;
                            c_waddr = phys(r_head, r_count);
                            n_count = r_count + ONE_C;
                        end else begin
                            // Shift the tail up, last entry first
                            n_ptr   = r_count - ONE_C;
                            n_rd_on = 1'b1;
                        end
                    end
                    plsu_pkg::REQ_REMOVE: begin
                        if (!c_pos_ok) begin
                            n_status = plsu_pkg::ST_BADPOS;
                        end else if (c_k == '0) begin
                            c_re    = 1'b1;
                            c_raddr = r_head;
                            n_head  = c_hinc;
                            n_count = r_count - ONE_C;
                        end else if (c_k == r_count - ONE_C) begin
                            c_re    = 1'b1;
                            c_raddr = phys(r_head, c_k);
                            n_count = r_count - ONE_C;
                        end else begin
                            // Read the removed entry, then pull the tail down
                            n_ptr   = c_k;
                            n_rd_on = 1'b1;
                        end
                    end
                    plsu_pkg::REQ_WRITE: begin
                        if (!c_pos_ok) begin
                            n_status = plsu_pkg::ST_BADPOS;
                        end else begin
                            c_we    = 1'b1;
                            c_waddr = phys(r_head, c_k);
                        end
                    end
                    plsu_pkg::REQ_READ: begin
                        if (!c_pos_ok) begin
                            n_status = plsu_pkg::ST_BADPOS;
                        end else begin
                            c_re    = 1'b1;
                            c_raddr = phys(r_head, c_k);
                        end
                    end
                    plsu_pkg::REQ_FIND: begin
                        if (!c_empty) begin
                            n_ptr   = '0;
                            n_rd_on = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            plsu_pkg::S_RDWAIT: begin
                n_rv = c_rdata;
            end
            plsu_pkg::S_INS: begin
                // Issue reads downward; write each returned entry one place up
                if (r_rd_on) begin
                    c_re    = 1'b1;
                    c_raddr = phys(r_head, r_ptr);
                    n_pv    = 1'b1;
                    n_pidx  = r_ptr;
                    if (r_ptr == c_k) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_ptr - ONE_C;
                    end
                end
                if (r_pv) begin
                    c_we    = 1'b1;
                    c_waddr = phys(r_head, r_pidx + ONE_C);
                    c_wdata = c_rdata;
                end
                if (!r_rd_on && !r_pv) begin
                    c_we    = 1'b1;
                    c_waddr = phys(r_head, c_k);
                    c_wdata = r_val;
                    n_count = r_count + ONE_C;
                end
            end
            plsu_pkg::S_REM: begin
                // Issue reads upward; first beat is the removed value
                if (r_rd_on) begin
                    c_re    = 1'b1;
                    c_raddr = phys(r_head, r_ptr);
                    n_pv    = 1'b1;
                    n_pidx  = r_ptr;
                    if (r_ptr == r_count - ONE_C) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ONE_C;
                    end
                end
                if (r_pv) begin
                    if (r_pidx == c_k) begin
                        n_rv = c_rdata;
                    end else begin
                        c_we    = 1'b1;
                        c_waddr = phys(r_head, r_pidx - ONE_C);
                        c_wdata = c_rdata;
                    end
                end
                if (!r_rd_on && !r_pv) begin
                    n_count = r_count - ONE_C;
                end
            end
            plsu_pkg::S_FIND: begin
                if (r_rd_on) begin
                    c_re    = 1'b1;
                    c_raddr = phys(r_head, r_ptr);
                    n_pv    = 1'b1;
                    n_pidx  = r_ptr;
                    if (r_ptr == r_count - ONE_C) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ONE_C;
                    end
                end
                // Stop at the first match and drop the read in flight
                if (c_match) begin
                    n_found = 1'b1;
                    n_fslot = r_pidx + ONE_C;
                    n_rv    = c_rdata;
                    n_rd_on = 1'b0;
                    n_pv    = 1'b0;
                end
            end
            plsu_pkg::S_FINISH: begin
                n_rd_on = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (c_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plsu_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_on     <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_on     <= n_rd_on;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_pidx   <= n_pidx;
        r_status <= n_status;
        r_rv     <= n_rv;
        r_fslot  <= n_fslot;
        r_found  <= n_found;
        if (c_accept) begin
            r_req  <= i_s_tuser;
            r_slot <= i_s_tdata[4:0];
            r_val  <= i_s_tdata[36:5];
        end
        if (c_load) begin
            r_o_status <= r_status;
            r_o_value  <= (r_status != plsu_pkg::ST_OK) ? plsu_pkg::ERR_VALUE : r_rv;
            r_o_fslot  <= c_fs_x[4:0];
            r_o_found  <= r_found;
            r_o_length <= c_len_x[4:0];
        end
    end

    assign o_s_tready = (r_state == plsu_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {5'b0, r_o_length, r_o_found, r_o_fslot, r_o_value};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_we && c_re) |-> (c_waddr != c_raddr))
        else $error("read and write hit the same entry in one cycle");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plsu_pkg::S_IDLE) |-> (!r_pv && !r_rd_on))
        else $error("read pipeline busy while idle");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != plsu_pkg::ST_OK) |-> (o_m_tdata[31:0] == plsu_pkg::ERR_VALUE))
        else $error("error beat without error value");

    a_found_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[37]) |-> (o_m_tdata[36:32] != 5'd0 || CW > 5))
        else $error("found beat with empty slot");

endmodule

>>> src/plsu_ram.sv
module plsu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
